// ----- hdl/timed_jerk_velocity_integrator_macros.svh -----
// Assertion macros for the timed jerk velocity integrator checker.
// No dependencies; included by the checker file only.
`ifndef TIMED_JERK_VELOCITY_INTEGRATOR_MACROS_SVH
`define TIMED_JERK_VELOCITY_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define TJVI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tjvi assertion failed");

// next-cycle implication
`define TJVI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tjvi assertion failed");

`endif

// ----- hdl/tjvi_pkg.sv -----
// Shared types and codes for the timed jerk velocity integrator.
// No dependencies.
package tjvi_pkg;

   localparam int AXES      = 3;
   localparam int VEL_W     = 32;
   localparam int TM2_W     = 33;
   localparam int CSR_IDX_W = 3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_IDLE  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_STEP  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 3'd6;

   localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
   localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [AXES-1:0][31:0] base_accel;
      logic [AXES-1:0][31:0] jerk;
      logic [31:0]           window_length;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- hdl/tjvi_if.sv -----
// Request and response channel interfaces of the velocity integrator.
// No dependencies.
interface tjvi_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [15:0]        step_time;
   logic signed [31:0] init_vel_x;
   logic signed [31:0] init_vel_y;
   logic signed [31:0] init_vel_z;

   modport source (output valid, op, step_time, init_vel_x, init_vel_y, init_vel_z,
                   input ready);
   modport sink (input valid, op, step_time, init_vel_x, init_vel_y, init_vel_z,
                 output ready);
endinterface

interface tjvi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_out_x;
   logic signed [31:0] vel_out_y;
   logic signed [31:0] vel_out_z;
   logic               vel_updated;
   logic               window_active;
   logic               window_done;
   logic               saturated;

   modport source (output valid, vel_out_x, vel_out_y, vel_out_z, vel_updated,
                   window_active, window_done, saturated, input ready);
   modport sink (input valid, vel_out_x, vel_out_y, vel_out_z, vel_updated,
                 window_active, window_done, saturated, output ready);
endinterface

// ----- hdl/timed_jerk_velocity_integrator.sv -----
// Top level of the timed jerk velocity integrator: register file, front end,
// command queue and integration back end. Depends on tjvi_pkg, tjvi_if, tjvi_front,
// tjvi_queue and tjvi_back.
//
//  channel   direction  handshake          contents
//  req_bus   in         valid/ready        op, step_time, init_vel_x/y/z
//  rsp_bus   out        valid/ready        vel_out_x/y/z and four status flags
//  csr_*     in         csr_wr_en only     register index, 32-bit write data
//
// Front end takes one beat per cycle while the two-entry queue has room.
// Back end: start, inactive tick and window-end items are written out directly; an
// integrating tick runs in sequence (32x33 multiply, round, accumulate, 32xF
// multiplies, round, saturate), all three axes in parallel lanes.
// Synchronous reset clears window state, velocity, queue and output valid.
// A stalled response holds the back end; requests keep queuing until the queue fills.
module timed_jerk_velocity_integrator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [tjvi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wr_data,
   tjvi_req_if.sink                          req_bus,
   tjvi_rsp_if.source                        rsp_bus
);
   import tjvi_pkg::*;

   localparam int CMD_W = 2 + FRAC_BITS + TM2_W + AXES * VEL_W;

   cfg_type          cfg_ff, cfg_in;
   q_status_type     q_status;
   logic             q_push;
   logic             q_pop;
   logic [CMD_W-1:0] q_wr_data;
   logic [CMD_W-1:0] q_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_X: cfg_in.base_accel[0] = csr_wr_data;
            CSR_BASE_Y: cfg_in.base_accel[1] = csr_wr_data;
            CSR_BASE_Z: cfg_in.base_accel[2] = csr_wr_data;
            CSR_JERK_X: cfg_in.jerk[0]       = csr_wr_data;
            CSR_JERK_Y: cfg_in.jerk[1]       = csr_wr_data;
            CSR_JERK_Z: cfg_in.jerk[2]       = csr_wr_data;
            CSR_WINDOW: cfg_in.window_length = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tjvi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .window_length (cfg_ff.window_length),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_data        (q_wr_data)
   );

   tjvi_queue #(.WIDTH(CMD_W)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   tjvi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_data   (q_rd_data),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ----- hdl/tjvi_front.sv -----
// Front end: accepts request beats, tracks window time and classifies each item.
// Depends on tjvi_pkg and tjvi_req_if.
module tjvi_front #(
   parameter int FRAC_BITS = 16,
   localparam int CMD_W = 2 + FRAC_BITS + tjvi_pkg::TM2_W + tjvi_pkg::AXES * tjvi_pkg::VEL_W
) (
   input  logic                   clock,
   input  logic                   reset,
   tjvi_req_if.sink               req_bus,
   input  logic [31:0]            window_length,
   input  tjvi_pkg::q_status_type q_status,
   output logic                   q_push,
   output logic [CMD_W-1:0]       q_data
);
   import tjvi_pkg::*;

   typedef struct packed {
      logic [1:0]                kind;
      logic [FRAC_BITS-1:0]      step;
      logic [TM2_W-1:0]          tm2;
      logic [AXES-1:0][VEL_W-1:0] init_vel;
   } cmd_type;

   cmd_type               cmd;
   logic [FRAC_BITS+15:0] wide;
   logic [FRAC_BITS-1:0]  step;
   logic [TM2_W-1:0]      sum;
   logic [TM2_W-1:0]      tm2;
   logic                  running_ff, running_in;
   logic [31:0]           elapsed_ff, elapsed_in;

   always_comb begin
      wide = (FRAC_BITS + 16)'(req_bus.step_time) << FRAC_BITS;
      step = wide[FRAC_BITS+15:16];
      sum  = {1'b0, elapsed_ff} + TM2_W'(step);
      tm2  = {elapsed_ff, 1'b0} + TM2_W'(step);

      cmd.step        = step;
      cmd.tm2         = tm2;
      cmd.init_vel[0] = req_bus.init_vel_x;
      cmd.init_vel[1] = req_bus.init_vel_y;
      cmd.init_vel[2] = req_bus.init_vel_z;
      running_in      = running_ff;
      elapsed_in      = elapsed_ff;

      if (req_bus.op == OP_START) begin
         cmd.kind   = KIND_START;
         running_in = 1'b1;
         elapsed_in = '0;
      end else if (!running_ff) begin
         cmd.kind = KIND_IDLE;
      end else if (sum > {1'b0, window_length}) begin
         cmd.kind   = KIND_END;
         running_in = 1'b0;
         elapsed_in = '0;
      end else begin
         cmd.kind   = KIND_STEP;
         elapsed_in = sum[31:0];
      end

      q_push = req_bus.valid && !q_status.full;
      q_data = cmd;
   end

   assign req_bus.ready = !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (q_push) begin
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ----- hdl/tjvi_queue.sv -----
// Two-entry command queue between front end and integration back end.
// Depends on tjvi_pkg.
module tjvi_queue #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       rd_data,
   output tjvi_pkg::q_status_type status
);
   import tjvi_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + 2'(do_push) - 2'(do_pop);
      rd_data      = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/tjvi_back.sv -----
// Back end: three axis lanes run the trapezoidal update through a short sequencer.
// Depends on tjvi_pkg and tjvi_rsp_if.
module tjvi_back #(
   parameter int FRAC_BITS = 16,
   localparam int CMD_W = 2 + FRAC_BITS + tjvi_pkg::TM2_W + tjvi_pkg::AXES * tjvi_pkg::VEL_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tjvi_pkg::cfg_type      cfg,
   input  logic [CMD_W-1:0]       q_data,
   input  tjvi_pkg::q_status_type q_status,
   output logic                   q_pop,
   tjvi_rsp_if.source             rsp_bus
);
   import tjvi_pkg::*;

   localparam int P_W   = 64;
   localparam int JM_W  = 63 - FRAC_BITS;
   localparam int ACC_W = 65 - FRAC_BITS;
   localparam int AM_W  = 64 - FRAC_BITS;
   localparam int PL_W  = 32 + FRAC_BITS;
   localparam int DM_W  = 64 - FRAC_BITS;
   localparam int R_W   = 66 - FRAC_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RND1 = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_RND2 = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   typedef struct packed {
      logic [1:0]                kind;
      logic [FRAC_BITS-1:0]      step;
      logic [TM2_W-1:0]          tm2;
      logic [AXES-1:0][VEL_W-1:0] init_vel;
   } cmd_type;

   cmd_type              head;
   logic                 out_free;
   logic                 write;
   logic                 clip_any;

   logic [2:0]           state_ff, state_in;
   logic [FRAC_BITS-1:0] step_ff, step_in;
   logic [P_W-1:0]       p_ff [AXES];
   logic [P_W-1:0]       p_in [AXES];
   logic [JM_W-1:0]      jm_ff [AXES];
   logic [JM_W-1:0]      jm_in [AXES];
   logic [AM_W-1:0]      am_ff [AXES];
   logic [AM_W-1:0]      am_in [AXES];
   logic                 neg_ff [AXES];
   logic                 neg_in [AXES];
   logic [31:0]          ph_ff [AXES];
   logic [31:0]          ph_in [AXES];
   logic [PL_W-1:0]      pl_ff [AXES];
   logic [PL_W-1:0]      pl_in [AXES];
   logic [DM_W-1:0]      dm_ff [AXES];
   logic [DM_W-1:0]      dm_in [AXES];
   logic [VEL_W-1:0]     vel_ff [AXES];
   logic [VEL_W-1:0]     vel_in [AXES];

   logic [VEL_W-1:0]     out_vel_ff [AXES];
   logic [VEL_W-1:0]     out_vel_in [AXES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 upd_ff, upd_in;
   logic                 act_ff, act_in;
   logic                 done_ff, done_in;
   logic                 sat_ff, sat_in;

   logic                 jneg [AXES];
   logic [31:0]          jmag [AXES];
   logic [P_W:0]         p_full [AXES];
   logic [P_W-1:0]       rnd1 [AXES];
   logic [ACC_W-1:0]     acc [AXES];
   logic [ACC_W-1:0]     acc_abs [AXES];
   logic [31:0]          ph [AXES];
   logic [PL_W-1:0]      pl [AXES];
   logic [P_W-1:0]       prod_rnd [AXES];
   logic [R_W-1:0]       dv [AXES];
   logic [R_W-1:0]       r_sum [AXES];
   logic [R_W-32:0]      r_hi [AXES];
   logic [VEL_W-1:0]     vel_new [AXES];
   logic                 clip [AXES];

   // per-axis datapath
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         jneg[i]     = cfg.jerk[i][31];
         jmag[i]     = jneg[i] ? (~cfg.jerk[i] + 32'd1) : cfg.jerk[i];
         p_full[i]   = (P_W + 1)'(jmag[i]) * (P_W + 1)'(head.tm2);
         rnd1[i]     = p_ff[i] + (P_W'(1) << FRAC_BITS);
         acc[i]      = {{(ACC_W - 32){cfg.base_accel[i][31]}}, cfg.base_accel[i]}
                       + (ACC_W'(jm_ff[i]) ^ {ACC_W{jneg[i]}}) + ACC_W'(jneg[i]);
         acc_abs[i]  = acc[i][ACC_W-1] ? (~acc[i] + ACC_W'(1)) : acc[i];
         ph[i]       = 32'(am_ff[i][AM_W-1:32]) * 32'(step_ff);
         pl[i]       = PL_W'(am_ff[i][31:0]) * PL_W'(step_ff);
         prod_rnd[i] = {ph_ff[i][30:0], 32'd0} + P_W'(pl_ff[i])
                       + (P_W'(1) << (FRAC_BITS - 1));
         dv[i]       = neg_ff[i] ? (~R_W'(dm_ff[i]) + R_W'(1)) : R_W'(dm_ff[i]);
         r_sum[i]    = {{(R_W - 32){vel_ff[i][31]}}, vel_ff[i]} + dv[i];
         r_hi[i]     = r_sum[i][R_W-1:31];
         if (ph_ff[i][31]) begin
            clip[i]    = 1'b1;
            vel_new[i] = neg_ff[i] ? VEL_MIN : VEL_MAX;
         end else if ((&r_hi[i]) || !(|r_hi[i])) begin
            clip[i]    = 1'b0;
            vel_new[i] = r_sum[i][31:0];
         end else begin
            clip[i]    = 1'b1;
            vel_new[i] = r_sum[i][R_W-1] ? VEL_MIN : VEL_MAX;
         end
      end
   end

   // sequencer
   always_comb begin
      head     = cmd_type'(q_data);
      out_free = !rsp_valid_ff || rsp_bus.ready;
      state_in = state_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      write    = 1'b0;
      upd_in   = 1'b0;
      act_in   = 1'b0;
      done_in  = 1'b0;
      clip_any = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         p_in[i]   = p_ff[i];
         jm_in[i]  = jm_ff[i];
         am_in[i]  = am_ff[i];
         neg_in[i] = neg_ff[i];
         ph_in[i]  = ph_ff[i];
         pl_in[i]  = pl_ff[i];
         dm_in[i]  = dm_ff[i];
         vel_in[i] = vel_ff[i];
         clip_any  = clip_any | clip[i];
      end
      sat_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               if (head.kind == KIND_STEP) begin
                  q_pop    = 1'b1;
                  step_in  = head.step;
                  state_in = ST_RND1;
                  for (int i = 0; i < AXES; i++) begin
                     p_in[i] = p_full[i][P_W-1:0];
                  end
               end else if (out_free) begin
                  q_pop   = 1'b1;
                  write   = 1'b1;
                  act_in  = (head.kind == KIND_START);
                  done_in = (head.kind == KIND_END);
                  if (head.kind == KIND_START) begin
                     for (int i = 0; i < AXES; i++) begin
                        vel_in[i] = head.init_vel[i];
                     end
                  end
               end
            end
         end
         ST_RND1: begin
            for (int i = 0; i < AXES; i++) begin
               jm_in[i] = rnd1[i][P_W-1:FRAC_BITS+1];
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            for (int i = 0; i < AXES; i++) begin
               am_in[i]  = acc_abs[i][AM_W-1:0];
               neg_in[i] = acc[i][ACC_W-1];
            end
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            for (int i = 0; i < AXES; i++) begin
               ph_in[i] = ph[i];
               pl_in[i] = pl[i];
            end
            state_in = ST_RND2;
         end
         ST_RND2: begin
            for (int i = 0; i < AXES; i++) begin
               dm_in[i] = prod_rnd[i][P_W-1:FRAC_BITS];
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               write    = 1'b1;
               upd_in   = 1'b1;
               act_in   = 1'b1;
               sat_in   = clip_any;
               state_in = ST_IDLE;
               for (int i = 0; i < AXES; i++) begin
                  vel_in[i] = vel_new[i];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      for (int i = 0; i < AXES; i++) begin
         out_vel_in[i] = vel_in[i];
      end
      rsp_valid_in = write ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            vel_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < AXES; i++) begin
            vel_ff[i] <= vel_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      for (int i = 0; i < AXES; i++) begin
         p_ff[i]   <= p_in[i];
         jm_ff[i]  <= jm_in[i];
         am_ff[i]  <= am_in[i];
         neg_ff[i] <= neg_in[i];
         ph_ff[i]  <= ph_in[i];
         pl_ff[i]  <= pl_in[i];
         dm_ff[i]  <= dm_in[i];
      end
      if (write) begin
         upd_ff  <= upd_in;
         act_ff  <= act_in;
         done_ff <= done_in;
         sat_ff  <= sat_in;
         for (int i = 0; i < AXES; i++) begin
            out_vel_ff[i] <= out_vel_in[i];
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.vel_out_x     = out_vel_ff[0];
   assign rsp_bus.vel_out_y     = out_vel_ff[1];
   assign rsp_bus.vel_out_z     = out_vel_ff[2];
   assign rsp_bus.vel_updated   = upd_ff;
   assign rsp_bus.window_active = act_ff;
   assign rsp_bus.window_done   = done_ff;
   assign rsp_bus.saturated     = sat_ff;

endmodule

// ----- hdl/tjvi_checker.sv -----
// Port-level checker for the timed jerk velocity integrator, bound to the top level.
// Depends on timed_jerk_velocity_integrator_macros.svh.
`include "timed_jerk_velocity_integrator_macros.svh"

module tjvi_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic vel_updated,
   input logic window_active,
   input logic window_done,
   input logic saturated
);

   `TJVI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TJVI_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `TJVI_ASSERT_IMP(a_done_flags, clock, reset, rsp_valid && window_done, !window_active && !vel_updated)
   `TJVI_ASSERT_IMP(a_sat_upd, clock, reset, rsp_valid && saturated, vel_updated)
   `TJVI_ASSERT_IMP(a_upd_active, clock, reset, rsp_valid && vel_updated, window_active)

endmodule

bind timed_jerk_velocity_integrator tjvi_checker u_tjvi_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .vel_updated   (rsp_bus.vel_updated),
   .window_active (rsp_bus.window_active),
   .window_done   (rsp_bus.window_done),
   .saturated     (rsp_bus.saturated)
);
